// ===== sv/mbrm_pkg.sv =====
// Shared types, codes and the CRC-16 step of the Modbus RTU master frame engine.
package mbrm_pkg;

	localparam logic [2:0] OP_WRITE_POWER = 3'd0;
	localparam logic [2:0] OP_READ_COILS  = 3'd1;
	localparam logic [2:0] OP_WRITE_COILS = 3'd2;
	localparam logic [2:0] OP_RX_BYTE     = 3'd3;
	localparam logic [2:0] OP_TIMEOUT     = 3'd4;

	localparam logic [1:0] CFG_INVERTER_ID     = 2'd0;
	localparam logic [1:0] CFG_RELAY_ID        = 2'd1;
	localparam logic [1:0] CFG_POWER_REGISTER  = 2'd2;
	localparam logic [1:0] CFG_INVERTER_ENABLE = 2'd3;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_TIMEOUT = 2'd1;
	localparam logic [1:0] ERR_CRC     = 2'd2;
	localparam logic [1:0] ERR_RELAY   = 2'd3;

	localparam logic [7:0]  FC_WRITE_REG   = 8'h06;
	localparam logic [7:0]  FC_READ_COILS  = 8'h01;
	localparam logic [7:0]  FC_WRITE_COILS = 8'h0F;
	localparam logic [7:0]  COIL_COUNT     = 8'h03;
	localparam logic [7:0]  COIL_BYTES     = 8'h01;
	localparam logic [7:0]  RELAY_ALL_OFF  = 8'd11;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] power_watts;
		logic [7:0]  relay_target;
		logic [7:0]  rx_byte;
	} cmd_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       tx_last;
		logic       done_res;
		logic       ok;
		logic [1:0] error_code;
		logic [3:0] sticky_flags;
		logic [3:0] coil_state;
		logic [2:0] coil_bits;
	} res_t;

	// One unit of work for the transmit/report engine.
	typedef struct packed {
		logic            is_frame;
		logic            len8;
		logic [7:0][7:0] frame;
		logic            ok;
		logic [1:0]      error_code;
		logic [3:0]      sticky_flags;
		logic [3:0]      coil_state;
		logic [2:0]      coil_bits;
	} job_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== sv/mbrm_fifo.sv =====
// Small register FIFO with a combinational head, used for the job and result queues.
module mbrm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// ===== sv/mbrm_front.sv =====
// Front end: configuration, command classification, reply tracking and job generation.
module mbrm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [15:0]       cfg_data,
	input  logic              accept,
	input  mbrm_pkg::cmd_t    cmd,
	output logic              job_push,
	output mbrm_pkg::job_t    job
);
	typedef enum logic [1:0] {KIND_IDLE, KIND_POWER, KIND_READ, KIND_WRITE} kind_t;

	logic [7:0]  inverter_id_q, relay_id_q;
	logic [15:0] power_reg_q;
	logic        inv_en_q;

	kind_t       kind_q, kind_d;
	logic [15:0] crc_q, crc_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [2:0]  coil_q, coil_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [3:0]  sticky_q, sticky_d;
	logic [2:0]  wbits_q, wbits_d;
	logic [3:0]  wstate_q, wstate_d;

	logic        job_valid;
	logic [15:0] watts;
	logic [2:0]  bits;
	logic [3:0]  lim;
	logic        good;
	logic        restart;
	kind_t       restart_kind;

	always_comb begin
		job          = '0;
		job_valid    = 1'b0;
		kind_d       = kind_q;
		crc_d        = crc_q;
		cnt_d        = cnt_q;
		coil_d       = coil_q;
		crc_lo_d     = crc_lo_q;
		sticky_d     = sticky_q;
		wbits_d      = wbits_q;
		wstate_d     = wstate_q;
		restart      = 1'b0;
		restart_kind = KIND_IDLE;
		watts        = inv_en_q ? cmd.power_watts : 16'h0000;
		bits         = '0;
		lim          = (kind_q == KIND_READ) ? 4'd3 : 4'd6;
		good         = ({cmd.rx_byte, crc_lo_q} == crc_q);

		unique case (cmd.opcode)
			mbrm_pkg::OP_WRITE_POWER: begin
				job.is_frame = 1'b1;
				job.frame[0] = inverter_id_q;
				job.frame[1] = mbrm_pkg::FC_WRITE_REG;
				job.frame[2] = power_reg_q[15:8];
				job.frame[3] = power_reg_q[7:0];
				job.frame[4] = watts[15:8];
				job.frame[5] = watts[7:0];
				job_valid    = 1'b1;
				restart      = 1'b1;
				restart_kind = KIND_POWER;
			end
			mbrm_pkg::OP_READ_COILS: begin
				job.is_frame = 1'b1;
				job.frame[0] = relay_id_q;
				job.frame[1] = mbrm_pkg::FC_READ_COILS;
				job.frame[5] = mbrm_pkg::COIL_COUNT;
				job_valid    = 1'b1;
				restart      = 1'b1;
				restart_kind = KIND_READ;
			end
			mbrm_pkg::OP_WRITE_COILS: begin
				job_valid = 1'b1;
				if (cmd.relay_target <= 8'd7 || cmd.relay_target == mbrm_pkg::RELAY_ALL_OFF) begin
					bits         = (cmd.relay_target <= 8'd7) ? cmd.relay_target[2:0] : 3'd0;
					job.is_frame = 1'b1;
					job.len8     = 1'b1;
					job.frame[0] = relay_id_q;
					job.frame[1] = mbrm_pkg::FC_WRITE_COILS;
					job.frame[5] = mbrm_pkg::COIL_COUNT;
					job.frame[6] = mbrm_pkg::COIL_BYTES;
					job.frame[7] = {5'd0, bits};
					wbits_d      = bits;
					wstate_d     = cmd.relay_target[3:0];
					restart      = 1'b1;
					restart_kind = KIND_WRITE;
				end else begin
					// reject: report only, keep any pending transaction
					job.error_code   = mbrm_pkg::ERR_RELAY;
					job.sticky_flags = sticky_q;
				end
			end
			mbrm_pkg::OP_RX_BYTE: begin
				if (kind_q != KIND_IDLE) begin
					if (cnt_q < lim) begin
						crc_d = mbrm_pkg::crc_byte(crc_q, cmd.rx_byte);
						if (kind_q == KIND_READ && cnt_q == 4'd2) begin
							coil_d = cmd.rx_byte[2:0];
						end
						cnt_d = cnt_q + 1'b1;
					end else if (cnt_q == lim) begin
						crc_lo_d = cmd.rx_byte;
						cnt_d    = cnt_q + 1'b1;
					end else begin
						job_valid = 1'b1;
						if (kind_q == KIND_POWER) begin
							sticky_d = good ? (sticky_q & 4'b1100) : (sticky_q | 4'b0010);
						end else begin
							sticky_d = good ? (sticky_q & 4'b0011) : (sticky_q | 4'b1000);
							if (good) begin
								job.coil_bits  = (kind_q == KIND_READ) ? coil_q : wbits_q;
								job.coil_state = (kind_q == KIND_READ) ? {1'b0, coil_q} : wstate_q;
							end
						end
						job.ok           = good;
						job.error_code   = good ? mbrm_pkg::ERR_NONE : mbrm_pkg::ERR_CRC;
						job.sticky_flags = sticky_d;
						restart          = 1'b1;
					end
				end
			end
			mbrm_pkg::OP_TIMEOUT: begin
				if (kind_q != KIND_IDLE) begin
					job_valid        = 1'b1;
					sticky_d         = (kind_q == KIND_POWER) ? (sticky_q | 4'b0001)
					                                          : (sticky_q | 4'b0100);
					job.error_code   = mbrm_pkg::ERR_TIMEOUT;
					job.sticky_flags = sticky_d;
					restart          = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (restart) begin
			crc_d    = mbrm_pkg::CRC_INIT;
			cnt_d    = '0;
			coil_d   = '0;
			crc_lo_d = '0;
			kind_d   = restart_kind;
		end
	end

	assign job_push = accept & job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverter_id_q <= 8'd1;
			relay_id_q    <= 8'd1;
			power_reg_q   <= 16'd3000;
			inv_en_q      <= 1'b0;
			kind_q        <= KIND_IDLE;
			crc_q         <= mbrm_pkg::CRC_INIT;
			cnt_q         <= '0;
			coil_q        <= '0;
			crc_lo_q      <= '0;
			sticky_q      <= '0;
			wbits_q       <= '0;
			wstate_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					mbrm_pkg::CFG_INVERTER_ID:     inverter_id_q <= cfg_data[7:0];
					mbrm_pkg::CFG_RELAY_ID:        relay_id_q    <= cfg_data[7:0];
					mbrm_pkg::CFG_POWER_REGISTER:  power_reg_q   <= cfg_data;
					mbrm_pkg::CFG_INVERTER_ENABLE: inv_en_q      <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				kind_q   <= kind_d;
				crc_q    <= crc_d;
				cnt_q    <= cnt_d;
				coil_q   <= coil_d;
				crc_lo_q <= crc_lo_d;
				sticky_q <= sticky_d;
				wbits_q  <= wbits_d;
				wstate_q <= wstate_d;
			end
		end
	end

endmodule

// ===== sv/mbrm_back.sv =====
// Back end: serializes frame jobs byte by byte with the trailing CRC, and turns report jobs into results.
module mbrm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_empty,
	input  mbrm_pkg::job_t    job,
	output logic              job_pop,
	input  logic              res_full,
	output logic              res_push,
	output mbrm_pkg::res_t    res
);
	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic [3:0]  len;
	logic        go;
	logic        last;
	logic [7:0]  byte_out;

	assign go   = ~job_empty & ~res_full;
	assign len  = job.len8 ? 4'd8 : 4'd6;
	assign last = (idx_q == len + 4'd1);

	always_comb begin
		if (idx_q < len) begin
			byte_out = job.frame[idx_q[2:0]];
		end else if (idx_q == len) begin
			byte_out = crc_q[7:0];
		end else begin
			byte_out = crc_q[15:8];
		end

		res = '0;
		if (job.is_frame) begin
			res.tx_valid = 1'b1;
			res.tx_byte  = byte_out;
			res.tx_last  = last;
		end else begin
			res.done_res     = 1'b1;
			res.ok           = job.ok;
			res.error_code   = job.error_code;
			res.sticky_flags = job.sticky_flags;
			res.coil_state   = job.coil_state;
			res.coil_bits    = job.coil_bits;
		end
	end

	assign res_push = go;
	assign job_pop  = go & (~job.is_frame | last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= mbrm_pkg::CRC_INIT;
		end else if (go && job.is_frame) begin
			if (last) begin
				idx_q <= '0;
				crc_q <= mbrm_pkg::CRC_INIT;
			end else begin
				idx_q <= idx_q + 1'b1;
				if (idx_q < len) begin
					crc_q <= mbrm_pkg::crc_byte(crc_q, byte_out);
				end
			end
		end
	end

endmodule

// ===== sv/modbus_rtu_master_frame_engine.sv =====
// Top level of the Modbus RTU master frame engine: front end, job queue, transmit engine, result queue.
//
// Modbus RTU master for an inverter and a relay board. Commands (write power, read coils,
// write coils) and reply events (received byte, timeout) are pushed in as transactions on the
// command queue; results come out of the result queue, oldest first. A command frame appears
// as 8 results (power write, coil read) or 10 results (coil write), one transmit byte each,
// ending in the CRC-16 low and high bytes; a finished, failed or rejected transaction gives
// one completion result. The front end takes one transaction per cycle whenever the job queue
// has room (full reflects only that queue), checks replies with one CRC byte step per cycle
// and updates the sticky error flags at once. The transmit engine behind the job queue emits
// one result per cycle while the result queue has room, so a frame holds it until its last
// byte; that engine and the consumer's pop rate set the sustained throughput. The first
// result of a transaction is registered in the job queue and then in the result queue before
// it reaches the result ports. Configuration writes take effect on the next edge and are meant
// to happen only while no transaction is in flight. No clearing pass is needed after reset.
module modbus_rtu_master_frame_engine #(
	parameter int JOB_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_idx,
	input  logic [15:0]    cfg_data,
	input  logic           push,
	output logic           full,
	input  mbrm_pkg::cmd_t cmd,
	output logic           empty,
	input  logic           pop,
	output mbrm_pkg::res_t res
);
	mbrm_pkg::job_t job_in, job_head;
	mbrm_pkg::res_t res_in;
	logic           job_push, job_full, job_empty, job_pop;
	logic           res_push, res_full;
	logic           accept;

	// Take a transaction whenever the job queue can hold whatever it produces.
	assign full   = job_full;
	assign accept = push & ~job_full;

	mbrm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.accept   (accept),
		.cmd      (cmd),
		.job_push (job_push),
		.job      (job_in)
	);

	mbrm_fifo #(
		.WIDTH ($bits(mbrm_pkg::job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_head),
		.empty  (job_empty)
	);

	mbrm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (job_head),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Hold finished results here so the transmit engine can run ahead of the consumer until this queue is full.
	mbrm_fifo #(
		.WIDTH ($bits(mbrm_pkg::res_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res),
		.empty  (empty)
	);

endmodule

// ===== sim/modbus_rtu_master_frame_engine_tb.sv =====
// Self-checking testbench for the Modbus RTU master frame engine: directed table, then random traffic.
module modbus_rtu_master_frame_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no transaction on either side before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Cycles to let the block settle once nothing is expected any more.
	localparam int SETTLE_CYCLES = 20;
	// Length of the long receiver hold-off that backs the block up.
	localparam int HOLD_CYCLES = 300;

	// Reply state of the slave link, as tracked by the predictor.
	typedef enum logic [1:0] {KIND_IDLE, KIND_POWER, KIND_READ, KIND_WRITE} kind_t;
	// Where the rx byte of a stimulus row comes from.
	typedef enum logic [1:0] {RX_AS_IS, RX_CRC_LO, RX_CRC_HI, RX_CRC_BAD} rx_src_t;
	// How a directed row is checked.
	typedef enum logic [1:0] {CHK_PREDICT, CHK_SILENT, CHK_FAIL} chk_t;

	typedef struct {
		mbrm_pkg::cmd_t c;
		rx_src_t        src;
		chk_t           chk;
		mbrm_pkg::res_t r;
	} stim_t;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic [1:0]     cfg_idx;
	logic [15:0]    cfg_data;
	logic           push;
	logic           full;
	mbrm_pkg::cmd_t cmd;
	logic           empty;
	logic           pop;
	mbrm_pkg::res_t res;

	modbus_rtu_master_frame_engine u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);

	// Predicted configuration.
	logic [7:0]  m_inv_id;
	logic [7:0]  m_relay_id;
	logic [15:0] m_preg;
	logic        m_inv_en;

	// Predicted reply tracking and sticky flags.
	logic [15:0] m_crc;
	int          m_count;
	kind_t       m_kind;
	logic [7:0]  m_coil;
	logic [7:0]  m_crc_lo;
	logic [3:0]  m_flags;
	logic [2:0]  m_wbits;
	logic [3:0]  m_wstate;

	// Results the block owes us, oldest first.
	mbrm_pkg::res_t due_results[$];

	int  errors;
	int  applied_items;
	int  tx_seen;
	int  done_seen;
	int  ok_seen;
	int  stall_cycles;
	bit  calm;
	bit  hold_req;
	int  burst;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One CRC-16 byte step, LSB first with the reflected polynomial.
	function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
		logic [15:0] acc;
		logic        lsb;
		acc = crc ^ {8'h00, b};
		repeat (8) begin
			lsb = acc[0];
			acc = acc >> 1;
			if (lsb)
				acc = acc ^ mbrm_pkg::CRC_POLY;
		end
		return acc;
	endfunction

	// Restart reply reception for a new pending transaction (or none).
	function automatic void rearm(kind_t kind);
		m_crc = mbrm_pkg::CRC_INIT;
		m_count = 0;
		m_coil = 8'h00;
		m_crc_lo = 8'h00;
		m_kind = kind;
	endfunction

	// Queue the transmit bytes of a request frame, CRC low byte then high byte.
	function automatic void queue_frame(logic [7:0] bytes [8], int len);
		logic [15:0]    crc;
		mbrm_pkg::res_t r;
		crc = mbrm_pkg::CRC_INIT;
		for (int i = 0; i < len; i++)
			crc = crc16_step(crc, bytes[i]);
		for (int i = 0; i < len + 2; i++) begin
			r = '0;
			r.tx_valid = 1'b1;
			r.tx_byte = (i < len) ? bytes[i] : (i == len) ? crc[7:0] : crc[15:8];
			r.tx_last = (i == len + 1);
			due_results.push_back(r);
		end
	endfunction

	// Advance the master by one input transaction; queue its results when record is set.
	// Return zero when the block simply ignores the transaction.
	function automatic bit master_step(mbrm_pkg::cmd_t c, bit record);
		logic [7:0]     f [8];
		logic [15:0]    w;
		logic [2:0]     bits;
		int             len;
		bit             good;
		mbrm_pkg::res_t d;
		master_step = 1'b1;
		f = '{default: 8'h00};
		d = '0;
		d.done_res = 1'b1;
		case (c.opcode)
			mbrm_pkg::OP_WRITE_POWER: begin
				// A disabled inverter is always sent zero watts.
				w = m_inv_en ? c.power_watts : 16'h0000;
				f[0] = m_inv_id;
				f[1] = mbrm_pkg::FC_WRITE_REG;
				f[2] = m_preg[15:8];
				f[3] = m_preg[7:0];
				f[4] = w[15:8];
				f[5] = w[7:0];
				rearm(KIND_POWER);
				if (record)
					queue_frame(f, 6);
			end
			mbrm_pkg::OP_READ_COILS: begin
				f[0] = m_relay_id;
				f[1] = mbrm_pkg::FC_READ_COILS;
				f[5] = mbrm_pkg::COIL_COUNT;
				rearm(KIND_READ);
				if (record)
					queue_frame(f, 6);
			end
			mbrm_pkg::OP_WRITE_COILS: begin
				if (c.relay_target <= 8'd7 || c.relay_target == mbrm_pkg::RELAY_ALL_OFF) begin
					bits = (c.relay_target == mbrm_pkg::RELAY_ALL_OFF) ? 3'b000
						: c.relay_target[2:0];
					f[0] = m_relay_id;
					f[1] = mbrm_pkg::FC_WRITE_COILS;
					f[5] = mbrm_pkg::COIL_COUNT;
					f[6] = mbrm_pkg::COIL_BYTES;
					f[7] = {5'b00000, bits};
					m_wbits = bits;
					m_wstate = c.relay_target[3:0];
					rearm(KIND_WRITE);
					if (record)
						queue_frame(f, 8);
				end else begin
					// Reject the state; keep whatever is pending.
					d.error_code = mbrm_pkg::ERR_RELAY;
					d.sticky_flags = m_flags;
					if (record)
						due_results.push_back(d);
				end
			end
			mbrm_pkg::OP_RX_BYTE: begin
				if (m_kind == KIND_IDLE) begin
					master_step = 1'b0;
				end else begin
					len = (m_kind == KIND_READ) ? 5 : 8;
					if (m_count + 2 < len) begin
						m_crc = crc16_step(m_crc, c.rx_byte);
						if (m_kind == KIND_READ && m_count == 2)
							m_coil = c.rx_byte;
						m_count++;
					end else if (m_count + 2 == len) begin
						m_crc_lo = c.rx_byte;
						m_count++;
					end else begin
						good = ({c.rx_byte, m_crc_lo} == m_crc);
						d.ok = good;
						d.error_code = good ? mbrm_pkg::ERR_NONE : mbrm_pkg::ERR_CRC;
						if (m_kind == KIND_POWER) begin
							m_flags = good ? (m_flags & 4'b1100) : (m_flags | 4'b0010);
						end else begin
							m_flags = good ? (m_flags & 4'b0011) : (m_flags | 4'b1000);
							if (good && m_kind == KIND_READ) begin
								d.coil_bits = m_coil[2:0];
								d.coil_state = {1'b0, m_coil[2:0]};
							end else if (good) begin
								d.coil_bits = m_wbits;
								d.coil_state = m_wstate;
							end
						end
						d.sticky_flags = m_flags;
						rearm(KIND_IDLE);
						if (record)
							due_results.push_back(d);
					end
				end
			end
			mbrm_pkg::OP_TIMEOUT: begin
				if (m_kind == KIND_IDLE) begin
					master_step = 1'b0;
				end else begin
					m_flags = m_flags | ((m_kind == KIND_POWER) ? 4'b0001 : 4'b0100);
					d.error_code = mbrm_pkg::ERR_TIMEOUT;
					d.sticky_flags = m_flags;
					rearm(KIND_IDLE);
					if (record)
						due_results.push_back(d);
				end
			end
			default: master_step = 1'b0;
		endcase
	endfunction

	// Build one directed row; a typed failure carries done, not ok, the code and the flags.
	function automatic stim_t stim(logic [2:0] op, logic [15:0] w, logic [7:0] t,
			logic [7:0] rx, rx_src_t src, chk_t chk, logic [1:0] code, logic [3:0] flags);
		stim_t s;
		s.c.opcode = op;
		s.c.power_watts = w;
		s.c.relay_target = t;
		s.c.rx_byte = rx;
		s.src = src;
		s.chk = chk;
		s.r = '0;
		s.r.done_res = 1'b1;
		s.r.error_code = code;
		s.r.sticky_flags = flags;
		return s;
	endfunction

	// Offer one transaction at a falling edge, hold it until taken, then predict.
	task automatic send(mbrm_pkg::cmd_t c, rx_src_t src, chk_t chk, mbrm_pkg::res_t r);
		if (!calm && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 19)) @(negedge clk);
		case (src)
			RX_CRC_LO:  c.rx_byte = m_crc[7:0];
			RX_CRC_HI:  c.rx_byte = m_crc[15:8];
			RX_CRC_BAD: c.rx_byte = m_crc[15:8] ^ 8'h5A;
			default: ;
		endcase
		cmd = c;
		push = 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		applied_items += master_step(c, chk == CHK_PREDICT);
		if (chk == CHK_FAIL)
			due_results.push_back(r);
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_idx = idx;
		cfg_data = data;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			mbrm_pkg::CFG_INVERTER_ID:     m_inv_id = data[7:0];
			mbrm_pkg::CFG_RELAY_ID:        m_relay_id = data[7:0];
			mbrm_pkg::CFG_POWER_REGISTER:  m_preg = data;
			mbrm_pkg::CFG_INVERTER_ENABLE: m_inv_en = data[0];
			default: ;
		endcase
	endtask

	// Hold the sender until every owed result is out, then let the block go quiet.
	task automatic drain();
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Random traffic: mostly a command followed by a full reply with a good CRC; some replies
	// carry a bad CRC, stop short and time out, or get cut off by the next command; a few
	// transactions are pure noise.
	task automatic random_phase(int goal);
		int             base;
		int             pick;
		int             mode;
		int             len;
		int             cut;
		int             sel;
		logic [31:0]    rnd;
		mbrm_pkg::cmd_t c;
		rx_src_t        src;
		base = applied_items;
		while (applied_items - base < goal) begin
			pick = $urandom_range(0, 99);
			rnd = $urandom;
			c.power_watts = rnd[15:0];
			c.relay_target = rnd[23:16];
			c.rx_byte = rnd[31:24];
			rnd = $urandom;
			if (pick < 8) begin
				c.opcode = rnd[2:0];
				send(c, RX_AS_IS, CHK_PREDICT, '0);
			end else begin
				if (pick < 38) begin
					c.opcode = mbrm_pkg::OP_WRITE_POWER;
				end else if (pick < 66) begin
					c.opcode = mbrm_pkg::OP_READ_COILS;
				end else begin
					c.opcode = mbrm_pkg::OP_WRITE_COILS;
					// Mostly legal relay states; the rest stay fully random.
					if ($urandom_range(0, 4) != 0) begin
						sel = $urandom_range(0, 8);
						c.relay_target = (sel == 8) ? mbrm_pkg::RELAY_ALL_OFF : 8'(sel);
					end
				end
				send(c, RX_AS_IS, CHK_PREDICT, '0);
				if (m_kind != KIND_IDLE) begin
					len = (m_kind == KIND_READ) ? 5 : 8;
					mode = $urandom_range(0, 99);
					cut = (mode < 80) ? len : $urandom_range(0, len - 1);
					for (int i = 0; i < cut; i++) begin
						rnd = $urandom;
						c.opcode = mbrm_pkg::OP_RX_BYTE;
						c.power_watts = rnd[15:0];
						c.relay_target = rnd[23:16];
						c.rx_byte = rnd[31:24];
						if (i == len - 2)
							src = (mode < 75) ? RX_CRC_LO : RX_AS_IS;
						else if (i == len - 1)
							src = (mode < 70) ? RX_CRC_HI : RX_CRC_BAD;
						else
							src = RX_AS_IS;
						send(c, src, CHK_PREDICT, '0);
					end
					// Short replies mostly end in a timeout; the rest are dropped by the next command.
					if (mode >= 80 && mode < 92) begin
						c.opcode = mbrm_pkg::OP_TIMEOUT;
						send(c, RX_AS_IS, CHK_PREDICT, '0);
					end
				end
			end
		end
	endtask

	// Receiver: random stall bursts, one long hold-off on request, none in the calm stretch.
	initial begin
		pop = 1'b0;
		burst = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pop = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (burst > 0) begin
				pop = 1'b0;
				burst--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				pop = 1'b0;
				burst = $urandom_range(1, 19) - 1;
			end else begin
				pop = 1'b1;
			end
		end
	end

	task automatic check_field(string fname, int unsigned want, int unsigned seen);
		if (want != seen) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, seen);
			errors++;
		end
	endtask

	// Compare every result transaction against the oldest owed result; count idle cycles.
	always @(posedge clk) begin
		if (arst_n && ((push && !full) || (pop && !empty)))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (arst_n && pop && !empty) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, res);
				errors++;
			end else begin
				check_field("tx_valid", due_results[0].tx_valid, res.tx_valid);
				check_field("tx_byte", due_results[0].tx_byte, res.tx_byte);
				check_field("tx_last", due_results[0].tx_last, res.tx_last);
				check_field("done_res", due_results[0].done_res, res.done_res);
				check_field("ok", due_results[0].ok, res.ok);
				check_field("error_code", due_results[0].error_code, res.error_code);
				check_field("sticky_flags", due_results[0].sticky_flags, res.sticky_flags);
				check_field("coil_state", due_results[0].coil_state, res.coil_state);
				check_field("coil_bits", due_results[0].coil_bits, res.coil_bits);
				if (due_results[0].tx_valid)
					tx_seen++;
				else
					done_seen++;
				if (due_results[0].ok)
					ok_seen++;
				void'(due_results.pop_front());
			end
		end
	end

	// Watchdog: end the run when nothing has moved for too long.
	initial begin
		do
			@(posedge clk);
		while (stall_cycles < STALL_LIMIT);
		$display("%0t: no transaction for %0d cycles, %0d results still owed",
			$time, STALL_LIMIT, due_results.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin
		stim_t       directed [25];
		logic [31:0] rnd;
		logic [31:0] rnd2;

		// Drive every input to a known value and hold reset until the directed table is built.
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = mbrm_pkg::CFG_INVERTER_ID;
		cfg_data = 16'h0000;
		push = 1'b0;
		cmd = '0;
		errors = 0;
		applied_items = 0;
		tx_seen = 0;
		done_seen = 0;
		ok_seen = 0;
		stall_cycles = 0;
		calm = 1'b0;
		hold_req = 1'b0;

		// Registers at their reset values.
		m_inv_id = 8'd1;
		m_relay_id = 8'd1;
		m_preg = 16'd3000;
		m_inv_en = 1'b0;
		m_flags = 4'h0;
		m_wbits = 3'b000;
		m_wstate = 4'h0;
		rearm(KIND_IDLE);

		// Ignored while idle: stray byte, stray timeout, unused opcodes.
		directed[0]  = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, 8'hFF, RX_AS_IS, CHK_SILENT,
			mbrm_pkg::ERR_NONE, 4'h0);
		directed[1]  = stim(mbrm_pkg::OP_TIMEOUT, 16'hFFFF, 8'hFF, 8'h00, RX_AS_IS, CHK_SILENT,
			mbrm_pkg::ERR_NONE, 4'h0);
		directed[2]  = stim(3'd5, 16'h0000, 8'h00, 8'h00, RX_AS_IS, CHK_SILENT,
			mbrm_pkg::ERR_NONE, 4'h0);
		directed[3]  = stim(3'd7, 16'hFFFF, 8'hFF, 8'hFF, RX_AS_IS, CHK_SILENT,
			mbrm_pkg::ERR_NONE, 4'h0);
		// Out-of-range relay state is rejected with the current (clear) flags.
		directed[4]  = stim(mbrm_pkg::OP_WRITE_COILS, 16'h0000, 8'hFF, 8'h00, RX_AS_IS,
			CHK_FAIL, mbrm_pkg::ERR_RELAY, 4'h0);
		// Full-scale power on a disabled inverter goes out as zero watts, then times out.
		directed[5]  = stim(mbrm_pkg::OP_WRITE_POWER, 16'hFFFF, 8'h00, 8'h00, RX_AS_IS,
			CHK_PREDICT, mbrm_pkg::ERR_NONE, 4'h0);
		directed[6]  = stim(mbrm_pkg::OP_TIMEOUT, 16'h0000, 8'h00, 8'h00, RX_AS_IS, CHK_FAIL,
			mbrm_pkg::ERR_TIMEOUT, 4'b0001);
		// Each new command silently drops the one still pending.
		directed[7]  = stim(mbrm_pkg::OP_READ_COILS, 16'h0000, 8'h00, 8'h00, RX_AS_IS,
			CHK_PREDICT, mbrm_pkg::ERR_NONE, 4'h0);
		directed[8]  = stim(mbrm_pkg::OP_WRITE_POWER, 16'h0000, 8'h00, 8'h00, RX_AS_IS,
			CHK_PREDICT, mbrm_pkg::ERR_NONE, 4'h0);
		directed[9]  = stim(mbrm_pkg::OP_WRITE_COILS, 16'h0000, mbrm_pkg::RELAY_ALL_OFF, 8'h00,
			RX_AS_IS, CHK_PREDICT, mbrm_pkg::ERR_NONE, 4'h0);
		// A rejected state leaves the all-off write pending.
		directed[10] = stim(mbrm_pkg::OP_WRITE_COILS, 16'h0000, 8'd8, 8'h00, RX_AS_IS, CHK_FAIL,
			mbrm_pkg::ERR_RELAY, 4'b0001);
		// Good reply to the all-off write: reports state 11 with all bits off.
		directed[11] = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, 8'h01, RX_AS_IS, CHK_PREDICT,
			mbrm_pkg::ERR_NONE, 4'h0);
		directed[12] = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, mbrm_pkg::FC_WRITE_COILS,
			RX_AS_IS, CHK_PREDICT, mbrm_pkg::ERR_NONE, 4'h0);
		directed[13] = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, 8'h00, RX_AS_IS, CHK_PREDICT,
			mbrm_pkg::ERR_NONE, 4'h0);
		directed[14] = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, 8'h00, RX_AS_IS, CHK_PREDICT,
			mbrm_pkg::ERR_NONE, 4'h0);
		directed[15] = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, 8'h00, RX_AS_IS, CHK_PREDICT,
			mbrm_pkg::ERR_NONE, 4'h0);
		directed[16] = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, mbrm_pkg::COIL_COUNT,
			RX_AS_IS, CHK_PREDICT, mbrm_pkg::ERR_NONE, 4'h0);
		directed[17] = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, 8'h00, RX_CRC_LO,
			CHK_PREDICT, mbrm_pkg::ERR_NONE, 4'h0);
		directed[18] = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, 8'h00, RX_CRC_HI,
			CHK_PREDICT, mbrm_pkg::ERR_NONE, 4'h0);
		// Coil read whose reply carries a coil byte of all ones and a corrupt CRC high byte.
		directed[19] = stim(mbrm_pkg::OP_READ_COILS, 16'h0000, 8'h00, 8'h00, RX_AS_IS,
			CHK_PREDICT, mbrm_pkg::ERR_NONE, 4'h0);
		directed[20] = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, 8'h01, RX_AS_IS, CHK_PREDICT,
			mbrm_pkg::ERR_NONE, 4'h0);
		directed[21] = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, mbrm_pkg::FC_READ_COILS,
			RX_AS_IS, CHK_PREDICT, mbrm_pkg::ERR_NONE, 4'h0);
		directed[22] = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, 8'hFF, RX_AS_IS, CHK_PREDICT,
			mbrm_pkg::ERR_NONE, 4'h0);
		directed[23] = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, 8'h00, RX_CRC_LO,
			CHK_PREDICT, mbrm_pkg::ERR_NONE, 4'h0);
		directed[24] = stim(mbrm_pkg::OP_RX_BYTE, 16'h0000, 8'h00, 8'h00, RX_CRC_BAD, CHK_FAIL,
			mbrm_pkg::ERR_CRC, 4'b1001);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < $size(directed); i++)
			send(directed[i].c, directed[i].src, directed[i].chk, directed[i].r);

		// Four random phases, each under its own register setting: low extremes,
		// high extremes, then two random settings; the last one runs with no idling.
		for (int p = 0; p < 4; p++) begin
			drain();
			rnd = $urandom;
			rnd2 = $urandom;
			case (p)
				0: begin
					write_reg(mbrm_pkg::CFG_INVERTER_ID, 16'h0000);
					write_reg(mbrm_pkg::CFG_RELAY_ID, 16'h0000);
					write_reg(mbrm_pkg::CFG_POWER_REGISTER, 16'h0000);
					write_reg(mbrm_pkg::CFG_INVERTER_ENABLE, 16'h0001);
				end
				1: begin
					write_reg(mbrm_pkg::CFG_INVERTER_ID, 16'h00FF);
					write_reg(mbrm_pkg::CFG_RELAY_ID, 16'h00FF);
					write_reg(mbrm_pkg::CFG_POWER_REGISTER, 16'hFFFF);
					write_reg(mbrm_pkg::CFG_INVERTER_ENABLE, 16'h0000);
				end
				default: begin
					write_reg(mbrm_pkg::CFG_INVERTER_ID, {8'h00, rnd[7:0]});
					write_reg(mbrm_pkg::CFG_RELAY_ID, {8'h00, rnd[15:8]});
					write_reg(mbrm_pkg::CFG_POWER_REGISTER, rnd2[15:0]);
					write_reg(mbrm_pkg::CFG_INVERTER_ENABLE,
						(p == 2) ? 16'h0001 : {15'h0000, rnd[16]});
				end
			endcase
			calm = (p == 3);
			if (p == 0) begin
				// Stall the receiver and keep pushing frames until the input backs up.
				hold_req = 1'b1;
				repeat (6)
					send(mbrm_pkg::cmd_t'({mbrm_pkg::OP_READ_COILS, 16'h0000, 8'h00, 8'h00}),
						RX_AS_IS, CHK_PREDICT, '0);
			end
			random_phase(40);
		end

		drain();
		$display("Applied %0d transactions that the block acted on, under 5 register settings.",
			applied_items);
		$display("Checked %0d transmit bytes and %0d completions (%0d ok), stalls on both sides.",
			tx_seen, done_seen, ok_seen);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
